// ===== hw/rtl/lts_pkg.sv =====
`default_nettype none
// ============================================================================
// lts_pkg: shared types and constants of the line tracker steering core
// Item kinds, run modes, controller states, register indexes and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package lts_pkg;

    // Item kinds carried on req_type
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_START  = 2'd2,
        REQ_STOP   = 2'd3
    } req_t;

    // Run modes as shown on the mode output
    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_READY  = 3'd1,
        MODE_FOLLOW = 3'd2,
        MODE_TURN   = 3'd3,
        MODE_STOP   = 3'd4
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_DIV   = 3'd1,
        ST_APPLY = 3'd2,
        ST_MUL_P = 3'd3,
        ST_MUL_D = 3'd4,
        ST_CMD   = 3'd5,
        ST_OUT   = 3'd6
    } ctrl_state_t;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_KP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_POLARITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_FRAMES     = 3'd4;

    // Register reset values
    localparam logic       FOLLOW_ENABLE_RST  = 1'b0;
    localparam logic [7:0] STEER_KP_RST       = 8'd64;
    localparam logic [7:0] STEER_KD_RST       = 8'd0;
    localparam logic [1:0] MOTOR_POLARITY_RST = 2'b11;
    localparam logic [3:0] GAP_FRAMES_RST     = 4'd3;

    // Drive word width and the reciprocal used for a divide by three
    localparam int CMD_W       = 16;
    localparam int THIRD_SHIFT = 17;
    localparam logic [16:0] THIRD_RECIP = 17'd43691;

    // White frame counter saturates here
    localparam logic [7:0] WHITE_MAX = 8'd255;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic div_step;
        logic apply;
        logic mul_p;
        logic mul_d;
        logic cmd_calc;
        logic out_load;
    } lts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        req_t kind;
        logic div_done;
        logic out_free;
    } lts_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/line_tracker_steering.sv =====
`default_nettype none
// Stages: a sensor sample runs the bit-serial divider (one quotient bit per cycle),
//   over M bits, M being the centroid magnitude width (5 at SENSOR_COUNT = 8), then
//   the update and output stages; a control tick adds the steering products and
//   command stages; start/stop go from the update to the output stage. One item at a
//   time: the next beat is taken while the previous result waits in the output register.
// Reset: rst_n clears mode, tracker state, wheel commands and loads register defaults.
// ============================================================================
// line_tracker_steering: line follower core
// Sensor centroid with gap hold, run mode machine and PD steering / spin
// search wheel commands, built as a sequencer plus a datapath.
// ============================================================================
module line_tracker_steering
    import lts_pkg::*;
#(
    parameter int SENSOR_COUNT     = 8,
    parameter int SEARCH_THRESHOLD = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    // items
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               req_type,
    input  wire logic [SENSOR_COUNT-1:0]  sensor_bits,
    input  wire logic signed [15:0]       feedforward_pwm,
    input  wire logic signed [15:0]       correction_left,
    input  wire logic signed [15:0]       correction_right,
    input  wire logic signed [15:0]       start_speed,
    // results
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [2:0]                    mode,
    output logic signed [3:0]             line_position,
    output logic                          line_lost,
    output logic                          position_guessed,
    output logic signed [15:0]            left_command,
    output logic signed [15:0]            right_command
);

    lts_cmd_t    cmd;
    lts_status_t status;
    req_t        req_kind;

    assign req_kind = req_t'(req_type);

    // Sequence one item at a time
    lts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_kind),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Compute position, mode and wheel commands
    lts_datapath #(
        .SENSOR_COUNT     (SENSOR_COUNT),
        .SEARCH_THRESHOLD (SEARCH_THRESHOLD)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_kind),
        .sensor_bits      (sensor_bits),
        .feedforward_pwm  (feedforward_pwm),
        .correction_left  (correction_left),
        .correction_right (correction_right),
        .start_speed      (start_speed),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .mode             (mode),
        .line_position    (line_position),
        .line_lost        (line_lost),
        .position_guessed (position_guessed),
        .left_command     (left_command),
        .right_command    (right_command)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lts_ctrl.sv =====
`default_nettype none
// ============================================================================
// lts_ctrl: item sequencer
// Accepts one beat at a time, walks it through divide (samples), update,
// steering products and command (ticks) stages, then to the output register.
// ============================================================================
module lts_ctrl
    import lts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  req_t             req_type,
    input  lts_status_t      status,
    output logic             in_ready,
    output lts_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the stages of one item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == REQ_SAMPLE) ? ST_DIV : ST_APPLY;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = (status.kind == REQ_TICK) ? ST_MUL_P : ST_OUT;
            end
            ST_MUL_P: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_CMD;
            ST_CMD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Drive commands for the current state
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_DIV:   cmd.div_step = 1'b1;
            ST_APPLY: cmd.apply    = 1'b1;
            ST_MUL_P: cmd.mul_p    = 1'b1;
            ST_MUL_D: cmd.mul_d    = 1'b1;
            ST_CMD:   cmd.cmd_calc = 1'b1;
            ST_OUT:   cmd.out_load = status.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lts_datapath.sv =====
`default_nettype none
// ============================================================================
// lts_datapath: line position, run mode and wheel command datapath
// Holds configuration and tracker state, a bit-serial centroid divider,
// the PD steering products, the spin search and the output register.
// ============================================================================
module lts_datapath
    import lts_pkg::*;
#(
    parameter int SENSOR_COUNT     = 8,
    parameter int SEARCH_THRESHOLD = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  lts_cmd_t                      cmd,
    output lts_status_t                   status,
    // configuration
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    // item fields
    input  req_t                          req_type,
    input  wire logic [SENSOR_COUNT-1:0]  sensor_bits,
    input  wire logic signed [CMD_W-1:0]  feedforward_pwm,
    input  wire logic signed [CMD_W-1:0]  correction_left,
    input  wire logic signed [CMD_W-1:0]  correction_right,
    input  wire logic signed [CMD_W-1:0]  start_speed,
    // results
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic [2:0]                    mode,
    output logic signed [3:0]             line_position,
    output logic                          line_lost,
    output logic                          position_guessed,
    output logic signed [CMD_W-1:0]       left_command,
    output logic signed [CMD_W-1:0]       right_command
);

    localparam int POS_W = $clog2(SENSOR_COUNT) + 1;
    localparam int SUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT / 4 + 1) + 1;
    localparam int MAG_W = SUM_W - 1;
    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam int REM_W = CNT_W + 1;
    localparam int DCW   = $clog2(MAG_W + 1);
    localparam int PD_W  = POS_W + 11;

    // Configuration registers
    logic       follow_enable_reg;
    logic [7:0] steer_kp_reg;
    logic [7:0] steer_kd_reg;
    logic [1:0] motor_polarity_reg;
    logic [3:0] gap_frames_reg;

    // Tracker state
    mode_t                   run_mode_reg;
    logic [14:0]             base_speed_reg;
    logic signed [POS_W-1:0] cur_pos_reg;
    logic                    lost_reg;
    logic signed [POS_W-1:0] held_pos_reg;
    logic [7:0]              white_count_reg;
    logic                    guess_reg;
    logic signed [POS_W-1:0] prev_err_reg;
    logic signed [CMD_W-1:0] left_cmd_reg;
    logic signed [CMD_W-1:0] right_cmd_reg;

    // Latched item
    req_t                    kind_reg;
    logic signed [CMD_W-1:0] ff_reg;
    logic signed [CMD_W-1:0] cl_reg;
    logic signed [CMD_W-1:0] cr_reg;
    logic signed [CMD_W-1:0] start_reg;
    logic                    all_see_reg;
    logic                    none_see_reg;
    logic                    sum_neg_reg;

    // Divider
    logic [REM_W-1:0] div_rem_reg;
    logic [MAG_W-1:0] div_quo_reg;
    logic [CNT_W-1:0] div_den_reg;
    logic [DCW-1:0]   div_cnt_reg;

    // Steering and search products
    logic signed [POS_W+8:0] p_prod_reg;
    logic signed [PD_W-1:0]  pd_sum_reg;
    logic [14:0]             third_mag_reg;

    // Output register
    logic                    out_valid_reg;
    mode_t                   out_mode_reg;
    logic signed [3:0]       out_pos_reg;
    logic                    out_lost_reg;
    logic                    out_guess_reg;
    logic signed [CMD_W-1:0] out_left_reg;
    logic signed [CMD_W-1:0] out_right_reg;

    // ------------------------------------------------------------------
    // Weighted sum and count of the sensors that see the line
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] bit_sum;
    logic [CNT_W-1:0]        bit_cnt;
    logic [MAG_W-1:0]        sum_mag;
    logic signed [SUM_W-1:0] sum_neg_val;

    always_comb
    begin
        bit_sum = '0;
        bit_cnt = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (!sensor_bits[i])
            begin
                bit_sum = bit_sum + SUM_W'(2 * i) - SUM_W'(SENSOR_COUNT - 1);
                bit_cnt = bit_cnt + CNT_W'(1);
            end
        end
        sum_neg_val = -bit_sum;
        sum_mag     = bit_sum[SUM_W-1] ? sum_neg_val[MAG_W-1:0] : bit_sum[MAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // Restoring divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [REM_W-1:0]        div_shift;
    logic                    div_fit;
    logic signed [POS_W-1:0] quo_pos;
    logic signed [POS_W-1:0] centroid;

    always_comb
    begin
        div_shift = REM_W'({div_rem_reg, div_quo_reg[MAG_W-1]});
        div_fit   = div_shift >= REM_W'(div_den_reg);
        quo_pos   = POS_W'(div_quo_reg);
        centroid  = sum_neg_reg ? -quo_pos : quo_pos;
    end

    // ------------------------------------------------------------------
    // Item effect followed by one mode step
    // ------------------------------------------------------------------
    mode_t                   mode_eff;
    mode_t                   mode_upd;
    logic [14:0]             base_upd;
    logic signed [POS_W-1:0] pos_upd;
    logic                    lost_upd;
    logic                    guess_upd;
    logic signed [POS_W-1:0] held_upd;
    logic [7:0]              white_upd;

    always_comb
    begin
        mode_eff  = run_mode_reg;
        base_upd  = base_speed_reg;
        pos_upd   = cur_pos_reg;
        lost_upd  = lost_reg;
        guess_upd = guess_reg;
        held_upd  = held_pos_reg;
        white_upd = white_count_reg;
        unique case (kind_reg)
            REQ_SAMPLE:
            begin
                if (!follow_enable_reg || all_see_reg)
                begin
                    pos_upd   = '0;
                    lost_upd  = 1'b0;
                    guess_upd = 1'b0;
                    white_upd = '0;
                end
                else if (none_see_reg)
                begin
                    if (white_count_reg != WHITE_MAX)
                    begin
                        white_upd = white_count_reg + 8'd1;
                    end
                    if (white_upd <= {4'd0, gap_frames_reg})
                    begin
                        pos_upd   = held_pos_reg;
                        lost_upd  = 1'b0;
                        guess_upd = 1'b1;
                    end
                    else
                    begin
                        pos_upd   = '0;
                        lost_upd  = 1'b1;
                        guess_upd = 1'b0;
                    end
                end
                else
                begin
                    pos_upd   = centroid;
                    lost_upd  = 1'b0;
                    guess_upd = 1'b0;
                    white_upd = '0;
                    held_upd  = centroid;
                end
            end
            REQ_START:
            begin
                base_upd = start_reg[CMD_W-1] ? '0 : start_reg[14:0];
                if (run_mode_reg == MODE_STOP)
                begin
                    mode_eff = MODE_READY;
                end
            end
            REQ_STOP:
            begin
                base_upd = '0;
                mode_eff = MODE_STOP;
            end
            REQ_TICK:
            begin
                mode_eff = run_mode_reg;
            end
        endcase

        mode_upd = mode_eff;
        unique case (mode_eff)
            MODE_INIT:  mode_upd = MODE_READY;
            MODE_READY:
            begin
                if (base_upd != '0)
                begin
                    mode_upd = MODE_FOLLOW;
                end
            end
            MODE_FOLLOW:
            begin
                if (follow_enable_reg && lost_upd && (white_upd > {4'd0, gap_frames_reg}))
                begin
                    mode_upd = MODE_TURN;
                end
            end
            MODE_TURN:
            begin
                if (!lost_upd)
                begin
                    mode_upd = MODE_FOLLOW;
                end
            end
            default:    mode_upd = mode_eff;
        endcase
    end

    // ------------------------------------------------------------------
    // Steering products and the divide-by-three of feedforward
    // ------------------------------------------------------------------
    logic signed [POS_W:0]   err_diff;
    logic signed [POS_W+8:0] p_prod;
    logic signed [POS_W+9:0] d_prod;
    logic                    ff_neg;
    logic [16:0]             ff_mag;
    logic [33:0]             third_prod;

    always_comb
    begin
        err_diff   = {cur_pos_reg[POS_W-1], cur_pos_reg} - {prev_err_reg[POS_W-1], prev_err_reg};
        p_prod     = $signed({1'b0, steer_kp_reg}) * cur_pos_reg;
        d_prod     = $signed({1'b0, steer_kd_reg}) * err_diff;
        ff_neg     = ff_reg[CMD_W-1];
        ff_mag     = ff_neg ? (17'd0 - {1'b1, ff_reg}) : {1'b0, ff_reg};
        third_prod = ff_mag * THIRD_RECIP;
    end

    // ------------------------------------------------------------------
    // Wheel commands for the current mode
    // ------------------------------------------------------------------
    logic                    steer_on;
    logic signed [PD_W-1:0]  pd_adj;
    logic signed [PD_W-1:0]  steer_full;
    logic signed [CMD_W-1:0] steer;
    logic signed [CMD_W-1:0] cl_eff;
    logic signed [CMD_W-1:0] cr_eff;
    logic signed [CMD_W-1:0] third_s;
    logic signed [CMD_W-1:0] half_s;
    logic signed [CMD_W-1:0] left_sel;
    logic signed [CMD_W-1:0] right_sel;

    function automatic logic signed [CMD_W-1:0] apply_polarity(
        input logic signed [CMD_W-1:0] value,
        input logic [1:0]              pol
    );
        logic signed [CMD_W-1:0] result;
        unique case (pol)
            2'b00:   result = '0;
            2'b01:   result = value;
            2'b11:   result = -value;
            default: result = -(value <<< 1);
        endcase
        return result;
    endfunction

    always_comb
    begin
        steer_on   = follow_enable_reg && !lost_reg;
        pd_adj     = pd_sum_reg + (pd_sum_reg[PD_W-1] ? PD_W'(15) : PD_W'(0));
        steer_full = pd_adj >>> 4;
        steer      = steer_on ? CMD_W'(steer_full) : '0;
        cl_eff     = (base_speed_reg != '0) ? cl_reg : '0;
        cr_eff     = (base_speed_reg != '0) ? cr_reg : '0;
        third_s    = ff_neg ? -CMD_W'(third_mag_reg) : CMD_W'(third_mag_reg);
        half_s     = ff_neg ? -CMD_W'(ff_mag[16:1]) : CMD_W'(ff_mag[16:1]);

        left_sel  = '0;
        right_sel = '0;
        if (run_mode_reg == MODE_FOLLOW)
        begin
            left_sel  = ff_reg + cl_eff + steer;
            right_sel = ff_reg + cr_eff - steer;
        end
        else if (run_mode_reg == MODE_TURN)
        begin
            if (int'(held_pos_reg) < -SEARCH_THRESHOLD)
            begin
                left_sel  = -third_s;
                right_sel = third_s;
            end
            else if (int'(held_pos_reg) > SEARCH_THRESHOLD)
            begin
                left_sel  = third_s;
                right_sel = -third_s;
            end
            else
            begin
                left_sel  = -half_s;
                right_sel = half_s;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_enable_reg  <= FOLLOW_ENABLE_RST;
            steer_kp_reg       <= STEER_KP_RST;
            steer_kd_reg       <= STEER_KD_RST;
            motor_polarity_reg <= MOTOR_POLARITY_RST;
            gap_frames_reg     <= GAP_FRAMES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FOLLOW_ENABLE:  follow_enable_reg  <= cfg_data[0];
                CFG_STEER_KP:       steer_kp_reg       <= cfg_data;
                CFG_STEER_KD:       steer_kd_reg       <= cfg_data;
                CFG_MOTOR_POLARITY: motor_polarity_reg <= cfg_data[1:0];
                CFG_GAP_FRAMES:     gap_frames_reg     <= cfg_data[3:0];
                default:            follow_enable_reg  <= follow_enable_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Latch the item and load the divider on an accepted beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg     <= req_type;
            ff_reg       <= feedforward_pwm;
            cl_reg       <= correction_left;
            cr_reg       <= correction_right;
            start_reg    <= start_speed;
            all_see_reg  <= (sensor_bits == '0);
            none_see_reg <= &sensor_bits;
            sum_neg_reg  <= bit_sum[SUM_W-1];
            div_den_reg  <= bit_cnt;
        end
    end

    // Shift the divider one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= sum_mag;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_fit ? (div_shift - REM_W'(div_den_reg)) : div_shift;
            div_quo_reg <= MAG_W'({div_quo_reg, div_fit});
        end
    end

    // Count divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            div_cnt_reg <= DCW'(MAG_W);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    // Register the steering products and the third of feedforward
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            third_mag_reg <= third_prod[THIRD_SHIFT+14:THIRD_SHIFT];
        end
        if (cmd.mul_p)
        begin
            p_prod_reg <= p_prod;
        end
        if (cmd.mul_d)
        begin
            pd_sum_reg <= PD_W'(p_prod_reg) + PD_W'(d_prod);
        end
    end

    // ------------------------------------------------------------------
    // Tracker state update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg    <= MODE_INIT;
            base_speed_reg  <= '0;
            cur_pos_reg     <= '0;
            lost_reg        <= 1'b0;
            held_pos_reg    <= '0;
            white_count_reg <= '0;
            guess_reg       <= 1'b0;
            prev_err_reg    <= '0;
            left_cmd_reg    <= '0;
            right_cmd_reg   <= '0;
        end
        else if (cmd.apply)
        begin
            run_mode_reg    <= mode_upd;
            base_speed_reg  <= base_upd;
            cur_pos_reg     <= pos_upd;
            lost_reg        <= lost_upd;
            held_pos_reg    <= held_upd;
            white_count_reg <= white_upd;
            guess_reg       <= guess_upd;
            if (kind_reg == REQ_STOP)
            begin
                left_cmd_reg  <= '0;
                right_cmd_reg <= '0;
            end
        end
        else if (cmd.cmd_calc)
        begin
            left_cmd_reg  <= apply_polarity(left_sel, motor_polarity_reg);
            right_cmd_reg <= apply_polarity(right_sel, motor_polarity_reg);
            if (run_mode_reg == MODE_FOLLOW && steer_on)
            begin
                prev_err_reg <= cur_pos_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mode_reg  <= run_mode_reg;
            out_pos_reg   <= lost_reg ? 4'sd0 : 4'(cur_pos_reg);
            out_lost_reg  <= lost_reg;
            out_guess_reg <= guess_reg;
            out_left_reg  <= left_cmd_reg;
            out_right_reg <= right_cmd_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mode             = out_mode_reg;
    assign line_position    = out_pos_reg;
    assign line_lost        = out_lost_reg;
    assign position_guessed = out_guess_reg;
    assign left_command     = out_left_reg;
    assign right_command    = out_right_reg;

    // Report status to the sequencer
    always_comb
    begin
        status.kind     = kind_reg;
        status.div_done = (div_cnt_reg == DCW'(1));
        status.out_free = !out_valid_reg || out_ready;
    end

endmodule
`default_nettype wire

// ===== sim/line_tracker_steering_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// line_tracker_steering_tb: self-checking bench for the line follower core
// A fixed list of sensor, tick, start and stop beats is walked first, then
// random beats in seven register settings under changing backpressure. Every
// result beat is checked field by field against the typed-in expectation
// (first directed block) or an in-bench tracker and steering predictor.
// ============================================================================
module line_tracker_steering_tb;
    import lts_pkg::*;

    localparam int SPIN_EDGE   = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        req_t               kind;
        logic [7:0]         bits;
        logic signed [15:0] ff;
        logic signed [15:0] cl;
        logic signed [15:0] cr;
        logic signed [15:0] ss;
    } tracker_in_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [3:0]  pos;
        logic               lost;
        logic               guess;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } tracker_out_t;

    typedef struct packed {
        logic               fe;
        logic [7:0]         kp;
        logic [7:0]         kd;
        logic signed [1:0]  pol;
        logic [3:0]         gap;
    } knobs_t;

    typedef struct packed {
        logic [3:0]   set_id;
        tracker_in_t  s;
        logic         typed;
        tracker_out_t want;
    } dir_row_t;

    // Register settings: reset values, directed, then one per random phase
    localparam knobs_t KNOB_SETS [0:8] = '{
        '{1'b0, 8'd64,  8'd0,   -2'sd1, 4'd3},
        '{1'b1, 8'd16,  8'd32,  2'sd1,  4'd2},
        '{1'b1, 8'd255, 8'd255, -2'sd1, 4'd0},
        '{1'b1, 8'd0,   8'd0,   2'sd1,  4'd15},
        '{1'b0, 8'd128, 8'd17,  2'sd0,  4'd5},
        '{1'b1, 8'd37,  8'd200, 2'sd1,  4'd4},
        '{1'b1, 8'd80,  8'd40,  -2'sd1, 4'd3},
        '{1'b1, 8'd90,  8'd45,  -2'sd1, 4'd15},
        '{1'b1, 8'd50,  8'd60,  2'sd1,  4'd6}
    };

    // Directed beats; the first block runs on reset settings and is typed in
    localparam dir_row_t DIR_ROWS [0:25] = '{
        '{4'd0, '{REQ_SAMPLE, 8'h3C, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b1, '{MODE_READY, 4'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0}},
        '{4'd0, '{REQ_TICK, 8'h00, 16'sd1000, 16'sd5, 16'sd7, 16'sd0},
            1'b1, '{MODE_READY, 4'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0}},
        '{4'd0, '{REQ_START, 8'h00, 16'sd0, 16'sd0, 16'sd0, -16'sd5},
            1'b1, '{MODE_READY, 4'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0}},
        '{4'd0, '{REQ_START, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd100},
            1'b1, '{MODE_FOLLOW, 4'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0}},
        '{4'd0, '{REQ_TICK, 8'h00, 16'sd100, 16'sd10, -16'sd20, 16'sd0},
            1'b1, '{MODE_FOLLOW, 4'sd0, 1'b0, 1'b0, -16'sd110, -16'sd80}},
        '{4'd0, '{REQ_TICK, 8'h00, 16'sd32767, 16'sd32767, 16'sh8000, 16'sd0},
            1'b1, '{MODE_FOLLOW, 4'sd0, 1'b0, 1'b0, 16'sd2, 16'sd1}},
        '{4'd0, '{REQ_STOP, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b1, '{MODE_STOP, 4'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0}},
        '{4'd0, '{REQ_START, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd32767},
            1'b1, '{MODE_FOLLOW, 4'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0}},
        '{4'd1, '{REQ_SAMPLE, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hF4, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_TICK, 8'h00, 16'sd200, 16'sd3, 16'sd4, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_TICK, 8'h00, -16'sd301, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFE, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_TICK, 8'h00, 16'sd300, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'h7F, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_TICK, 8'h00, 16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{4'd1, '{REQ_SAMPLE, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = '0;
    logic [7:0]         sensor_bits = '0;
    logic signed [15:0] feedforward_pwm = '0;
    logic signed [15:0] correction_left = '0;
    logic signed [15:0] correction_right = '0;
    logic signed [15:0] start_speed = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         mode;
    logic signed [3:0]  line_position;
    logic               line_lost;
    logic               position_guessed;
    logic signed [15:0] left_command;
    logic signed [15:0] right_command;

    // Predictor copy of registers and tracker state
    knobs_t knobs = KNOB_SETS[0];
    mode_t  trk_mode = MODE_INIT;
    int     speed = 0;
    int     pos = 0;
    int     held = 0;
    int     white = 0;
    int     prev_err = 0;
    int     cmd_l = 0;
    int     cmd_r = 0;
    logic   lost = 1'b0;
    logic   guess = 1'b0;

    tracker_out_t predicted_status [$];
    int     mismatches = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     white_left = 0;
    logic   hold_req = 1'b0;
    logic   hold_taken = 1'b0;
    int     hold_left = 0;
    int     quiet = 0;

    line_tracker_steering #(
        .SENSOR_COUNT     (8),
        .SEARCH_THRESHOLD (SPIN_EDGE)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .sensor_bits      (sensor_bits),
        .feedforward_pwm  (feedforward_pwm),
        .correction_left  (correction_left),
        .correction_right (correction_right),
        .start_speed      (start_speed),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mode             (mode),
        .line_position    (line_position),
        .line_lost        (line_lost),
        .position_guessed (position_guessed),
        .left_command     (left_command),
        .right_command    (right_command)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int wrap16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return t;
    endfunction

    // Advance the tracker by one beat and return the status it shows
    function automatic tracker_out_t track_and_steer(input tracker_in_t s);
        tracker_out_t r;
        int sum;
        int cnt;
        int ff;
        int cl;
        int cr;
        int steer;
        int l;
        int rt;
        sum = 0;
        cnt = 0;
        case (s.kind)
            REQ_SAMPLE:
            begin
                if (!knobs.fe || s.bits == 8'h00)
                begin
                    pos = 0; lost = 1'b0; guess = 1'b0; white = 0;
                end
                else
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (!s.bits[i])
                        begin
                            sum += 2 * i - 7;
                            cnt++;
                        end
                    end
                    if (cnt == 0)
                    begin
                        // white gap: hold the last position, then declare it lost
                        if (white < 255)
                            white++;
                        if (white <= int'(knobs.gap))
                        begin
                            pos = held; lost = 1'b0; guess = 1'b1;
                        end
                        else
                        begin
                            pos = 0; lost = 1'b1; guess = 1'b0;
                        end
                    end
                    else
                    begin
                        pos = sum / cnt;
                        lost = 1'b0; guess = 1'b0; white = 0;
                        held = pos;
                    end
                end
            end
            REQ_START:
            begin
                speed = (s.ss < 0) ? 0 : int'(s.ss);
                if (trk_mode == MODE_STOP)
                    trk_mode = MODE_READY;
            end
            REQ_STOP:
            begin
                speed = 0; cmd_l = 0; cmd_r = 0;
                trk_mode = MODE_STOP;
            end
            default: ;
        endcase

        // Take at most one mode step
        case (trk_mode)
            MODE_INIT:   trk_mode = MODE_READY;
            MODE_READY:  if (speed > 0) trk_mode = MODE_FOLLOW;
            MODE_FOLLOW: if (knobs.fe && lost && white > int'(knobs.gap)) trk_mode = MODE_TURN;
            MODE_TURN:   if (!lost) trk_mode = MODE_FOLLOW;
            default: ;
        endcase

        // Wheel commands on a control tick
        if (s.kind == REQ_TICK)
        begin
            ff = int'(s.ff);
            cl = (speed > 0) ? int'(s.cl) : 0;
            cr = (speed > 0) ? int'(s.cr) : 0;
            l = 0;
            rt = 0;
            if (trk_mode == MODE_FOLLOW)
            begin
                steer = 0;
                if (knobs.fe && !lost)
                begin
                    steer = (int'(knobs.kp) * pos + int'(knobs.kd) * (pos - prev_err)) / 16;
                    prev_err = pos;
                end
                l = wrap16(ff + cl + steer);
                rt = wrap16(ff + cr - steer);
            end
            else if (trk_mode == MODE_TURN)
            begin
                if (held < -SPIN_EDGE)
                begin
                    l = -ff / 3; rt = ff / 3;
                end
                else if (held > SPIN_EDGE)
                begin
                    l = ff / 3; rt = -ff / 3;
                end
                else
                begin
                    l = -ff / 2; rt = ff / 2;
                end
                l = wrap16(l);
                rt = wrap16(rt);
            end
            cmd_l = wrap16(l * int'(knobs.pol));
            cmd_r = wrap16(rt * int'(knobs.pol));
        end

        r.mode = trk_mode;
        r.pos = lost ? 4'sd0 : pos[3:0];
        r.lost = lost;
        r.guess = guess;
        r.left = cmd_l[15:0];
        r.right = cmd_r[15:0];
        return r;
    endfunction

    // Offer one beat, record its predicted status once it is taken
    task automatic offer_item(input tracker_in_t s, input logic typed, input tracker_out_t want);
        tracker_out_t model;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= s.kind;
        sensor_bits <= s.bits;
        feedforward_pwm <= s.ff;
        correction_left <= s.cl;
        correction_right <= s.cr;
        start_speed <= s.ss;
        do @(posedge clk); while (in_ready !== 1'b1);
        model = track_and_steer(s);
        predicted_status.push_back(typed ? want : model);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted status has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (predicted_status.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_knob(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic load_knobs(input knobs_t k);
        drain_results();
        write_knob(CFG_FOLLOW_ENABLE, {7'd0, k.fe});
        write_knob(CFG_STEER_KP, k.kp);
        write_knob(CFG_STEER_KD, k.kd);
        write_knob(CFG_MOTOR_POLARITY, {6'd0, k.pol});
        write_knob(CFG_GAP_FRAMES, {4'd0, k.gap});
        cfg_valid <= 1'b0;
        knobs = k;
    endtask

    // Random beat: mostly runs of line, white gaps and ticks, some raw noise
    task automatic pick_item(output tracker_in_t s);
        int pick;
        int w;
        s.kind = REQ_SAMPLE;
        s.bits = 8'($urandom);
        s.ff = 16'($urandom);
        s.cl = 16'($urandom);
        s.cr = 16'($urandom);
        s.ss = 16'($urandom);
        if ($urandom_range(3) != 0)
        begin
            s.ff = 16'($urandom_range(4000) - 2000);
            s.cl = 16'($urandom_range(400) - 200);
            s.cr = 16'($urandom_range(400) - 200);
        end
        if (white_left > 0)
        begin
            if ($urandom_range(4) == 0)
                s.kind = REQ_TICK;
            else
            begin
                s.bits = 8'hFF;
                white_left--;
            end
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                s.kind = REQ_STOP;
            else if (pick < 12)
            begin
                s.kind = REQ_START;
                if ($urandom_range(3) != 0)
                    s.ss = 16'($urandom_range(32767, 1));
            end
            else if (pick < 42)
                s.kind = REQ_TICK;
            else
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    white_left = $urandom_range(knobs.gap + 3, 1) - 1;
                    s.bits = 8'hFF;
                end
                else if (pick < 25)
                    s.bits = 8'h00;
                else if (pick < 80)
                begin
                    w = $urandom_range(3, 1);
                    s.bits = 8'hFF ^ (8'((1 << w) - 1) << $urandom_range(8 - w));
                end
            end
        end
    endtask

    // Result side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        tracker_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_status.size() == 0)
            begin
                $error("result beat with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = predicted_status.pop_front();
                if (mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, mode);
                    mismatches++;
                end
                if (line_position !== want.pos)
                begin
                    $error("line_position: expected %0d, got %0d", want.pos, line_position);
                    mismatches++;
                end
                if (line_lost !== want.lost)
                begin
                    $error("line_lost: expected %0d, got %0d", want.lost, line_lost);
                    mismatches++;
                end
                if (position_guessed !== want.guess)
                begin
                    $error("position_guessed: expected %0d, got %0d", want.guess,
                        position_guessed);
                    mismatches++;
                end
                if (left_command !== want.left)
                begin
                    $error("left_command: expected %0d, got %0d", want.left, left_command);
                    mismatches++;
                end
                if (right_command !== want.right)
                begin
                    $error("right_command: expected %0d, got %0d", want.right, right_command);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Reset, directed list, then random phases
    initial
    begin
        tracker_in_t item;
        knobs_t k;
        logic [3:0] cur_set;
        int n;
        cur_set = 4'd0;
        tx_idle_pct = 38;
        rx_idle_pct = 62;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIR_ROWS); i++)
        begin
            if (DIR_ROWS[i].set_id != cur_set)
            begin
                cur_set = DIR_ROWS[i].set_id;
                load_knobs(KNOB_SETS[cur_set]);
            end
            offer_item(DIR_ROWS[i].s, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            k = KNOB_SETS[ph + 2];
            if (ph == 4 || ph == 6)
            begin
                k.kp = 8'($urandom);
                k.kd = 8'($urandom);
                k.gap = 4'($urandom_range(15));
            end
            load_knobs(k);
            // swap the stall mix after two phases, then run without gaps after two more
            if (ph < 2)
            begin
                tx_idle_pct = 38; rx_idle_pct = 62;
            end
            else if (ph < 4)
            begin
                tx_idle_pct = 62; rx_idle_pct = 38;
            end
            else
            begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            if (ph == 4)
                hold_req = 1'b1;
            n = 58;
            // long white run pushes the white counter into saturation
            if (ph == 5)
            begin
                white_left = 262;
                n = 360;
            end
            repeat (n)
            begin
                pick_item(item);
                offer_item(item, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lts_pkg.sv
hw/rtl/lts_ctrl.sv
hw/rtl/lts_datapath.sv
hw/rtl/line_tracker_steering.sv
sim/line_tracker_steering_tb.sv
